[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules of the directory name lookup.
// Needs nothing else; each module includes this header inside its body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/ddnl_pkg.sv]
// Shared types, constants and helper functions of the directory name lookup.
// Depends on nothing; imported by disk_directory_name_lookup.
package ddnl_pkg;

  localparam int NAME_CHARS_DEF         = 16;
  localparam int ENTRIES_PER_SECTOR_DEF = 8;
  localparam int ENTRY_BYTES            = 32;
  localparam int NAME_SLOTS             = 16;
  localparam int NAME_START             = 5;

  // Byte positions inside one entry and inside one sector.
  localparam logic [4:0] POS_TYPE   = 5'd2;
  localparam logic [4:0] POS_TRACK  = 5'd3;
  localparam logic [4:0] POS_SECTOR = 5'd4;
  localparam logic [7:0] OFF_LINK_TRACK  = 8'd0;
  localparam logic [7:0] OFF_LINK_SECTOR = 8'd1;
  localparam logic [7:0] OFF_LAST        = 8'd255;

  // Result status codes.
  localparam logic [1:0] ST_FOLLOW    = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_CHAIN_END = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_NAME_HEAD    = 2'd0;
  localparam logic [1:0] REG_NAME_TAIL    = 2'd1;
  localparam logic [1:0] REG_SECTOR_LIMIT = 2'd2;

  localparam logic [7:0] SECTOR_LIMIT_RST = 8'd64;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;

  typedef logic [7:0] char_t;

  // Drop bit 7 and turn lower-case letters into upper case.
  function automatic char_t fold_char(input char_t c);
    char_t v;
    v = c & 8'd127;
    if (v >= 8'd97 && v <= 8'd122) begin
      v = v - 8'd32;
    end
    return v;
  endfunction

endpackage

[hw/rtl/disk_directory_name_lookup.sv]
// Directory name lookup over streamed directory sector bytes.
// Depends on ddnl_pkg and on assert_macros.svh.
//
// Feed the bytes of 256-byte directory sectors in order, one transfer each, with the
// byte in in_tdata[7:0], its offset in in_tdata[15:8] and in_tuser high on the first
// byte of a new lookup. The block takes one byte per cycle; each byte is latched in an
// input register and evaluated against the search state in the next cycle, and a result
// that it causes is registered in the output register. The only pause comes from the
// result register: while a result waits to be taken, the byte behind it waits too.
// A found result arrives with the last name byte of the matching entry; otherwise every
// sector ends with a result on its byte 255 (follow link, chain ended, or limit reached).
// Program the name and sector limit over the APB port only while no lookup is running.
module disk_directory_name_lookup #(
  parameter int NAME_CHARS         = ddnl_pkg::NAME_CHARS_DEF,
  parameter int ENTRIES_PER_SECTOR = ddnl_pkg::ENTRIES_PER_SECTOR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // byte_value[7:0], byte_offset[15:8]
  input  logic        in_tuser,    // new_search[0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // file_track, file_sector, next_track, next_sector
  output logic [1:0]  out_tuser,   // status[1:0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ddnl_pkg::*;
  `include "assert_macros.svh"

  localparam logic [4:0] NAME_LAST = 5'(NAME_START + NAME_CHARS - 1);
  localparam logic [4:0] NAME_FIRST = 5'(NAME_START);

  // Configuration registers.
  logic [63:0] name_head_r;
  logic [63:0] name_tail_r;
  logic [7:0]  sector_limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_head_r    <= '0;
      name_tail_r    <= '0;
      sector_limit_r <= SECTOR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        REG_NAME_HEAD:    name_head_r    <= cfg_pwdata;
        REG_NAME_TAIL:    name_tail_r    <= cfg_pwdata;
        REG_SECTOR_LIMIT: sector_limit_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_NAME_HEAD:    cfg_prdata = name_head_r;
      REG_NAME_TAIL:    cfg_prdata = name_tail_r;
      REG_SECTOR_LIMIT: cfg_prdata = {56'd0, sector_limit_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Folded, space-padded target name.
  char_t wanted [NAME_SLOTS];
  always_comb begin
    logic  seen_zero;
    char_t raw;
    seen_zero = 1'b0;
    for (int i = 0; i < NAME_SLOTS; i++) begin
      raw = (i < 8) ? name_head_r[8*(i%8) +: 8] : name_tail_r[8*(i%8) +: 8];
      seen_zero = seen_zero || (raw == 8'd0);
      wanted[i] = seen_zero ? CHAR_SPACE : fold_char(raw);
    end
  end

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_off_r;
  logic       s1_new_r;
  logic       s1_adv;

  // Output register.
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_ftrack_r;
  logic [7:0] out_fsector_r;
  logic [7:0] out_ntrack_r;
  logic [7:0] out_nsector_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[7:0];
      s1_off_r  <= in_tdata[15:8];
      s1_new_r  <= in_tuser;
    end
  end

  // Search state.
  logic [7:0] link_track_r,  link_track_nxt;
  logic [7:0] link_sector_r, link_sector_nxt;
  logic [7:0] cand_track_r,  cand_track_nxt;
  logic [7:0] cand_sector_r, cand_sector_nxt;
  logic       in_use_r,      in_use_nxt;
  logic       matching_r,    matching_nxt;
  logic [7:0] seen_r,        seen_nxt;
  logic       finished_r,    finished_nxt;

  logic       res_valid;
  logic [1:0] res_status;
  logic [7:0] res_ftrack;
  logic [7:0] res_fsector;

  always_comb begin
    logic [2:0] entry;
    logic [4:0] pos;
    logic [3:0] char_idx;
    logic [7:0] limit;
    logic       in_entries;

    entry      = s1_off_r[7:5];
    pos        = s1_off_r[4:0];
    char_idx   = 4'(pos - NAME_FIRST);
    limit      = (sector_limit_r == 8'd0) ? 8'd1 : sector_limit_r;
    in_entries = (int'(entry) < ENTRIES_PER_SECTOR);

    link_track_nxt  = link_track_r;
    link_sector_nxt = link_sector_r;
    cand_track_nxt  = cand_track_r;
    cand_sector_nxt = cand_sector_r;
    in_use_nxt      = in_use_r;
    matching_nxt    = matching_r;
    seen_nxt        = seen_r;
    finished_nxt    = finished_r;
    res_valid       = 1'b0;
    res_status      = ST_FOLLOW;
    res_ftrack      = 8'd0;
    res_fsector     = 8'd0;

    if (s1_new_r) begin
      finished_nxt    = 1'b0;
      seen_nxt        = 8'd0;
      link_track_nxt  = 8'd0;
      link_sector_nxt = 8'd0;
      in_use_nxt      = 1'b0;
      matching_nxt    = 1'b0;
    end

    if (!finished_nxt) begin
      if (s1_off_r == OFF_LINK_TRACK) begin
        link_track_nxt = s1_byte_r;
      end else if (s1_off_r == OFF_LINK_SECTOR) begin
        link_sector_nxt = s1_byte_r;
      end

      if (in_entries) begin
        if (pos == POS_TYPE) begin
          in_use_nxt   = (s1_byte_r[2:0] != 3'd0);
          matching_nxt = (s1_byte_r[2:0] != 3'd0);
        end else if (pos == POS_TRACK) begin
          cand_track_nxt = s1_byte_r;
        end else if (pos == POS_SECTOR) begin
          cand_sector_nxt = s1_byte_r;
        end else if (pos >= NAME_FIRST && pos <= NAME_LAST) begin
          if (fold_char(s1_byte_r) != wanted[char_idx]) begin
            matching_nxt = 1'b0;
          end
          if (pos == NAME_LAST && in_use_nxt && matching_nxt) begin
            finished_nxt = 1'b1;
            res_valid    = 1'b1;
            res_status   = ST_FOUND;
            res_ftrack   = cand_track_nxt;
            res_fsector  = cand_sector_nxt;
          end
        end
      end

      // The last name byte never sits at the last sector offset, so a found
      // result and a sector report cannot come from the same byte.
      if (!res_valid && s1_off_r == OFF_LAST) begin
        if (seen_nxt != 8'd255) begin
          seen_nxt = seen_nxt + 8'd1;
        end
        res_valid = 1'b1;
        if (link_track_nxt == 8'd0) begin
          finished_nxt = 1'b1;
          res_status   = ST_CHAIN_END;
        end else if (seen_nxt >= limit) begin
          finished_nxt = 1'b1;
          res_status   = ST_LIMIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_track_r  <= '0;
      link_sector_r <= '0;
      cand_track_r  <= '0;
      cand_sector_r <= '0;
      in_use_r      <= 1'b0;
      matching_r    <= 1'b0;
      seen_r        <= '0;
      finished_r    <= 1'b1;
    end else if (s1_adv) begin
      link_track_r  <= link_track_nxt;
      link_sector_r <= link_sector_nxt;
      cand_track_r  <= cand_track_nxt;
      cand_sector_r <= cand_sector_nxt;
      in_use_r      <= in_use_nxt;
      matching_r    <= matching_nxt;
      seen_r        <= seen_nxt;
      finished_r    <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_status_r  <= res_status;
      out_ftrack_r  <= res_ftrack;
      out_fsector_r <= res_fsector;
      out_ntrack_r  <= link_track_nxt;
      out_nsector_r <= link_sector_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_nsector_r, out_ntrack_r, out_fsector_r, out_ftrack_r};

  `ASSERT_IMPL(a_stall_holds_item, clk, rst_n, !in_tready, s1_valid_r)
  `ASSERT_IMPL(a_not_found_zero, clk, rst_n, out_tvalid && out_tuser != ST_FOUND,
               out_tdata[15:0] == 16'd0)
  `ASSERT_IMPL(a_chain_end_link, clk, rst_n, out_tvalid && out_tuser == ST_CHAIN_END,
               out_tdata[23:16] == 8'd0)
  `ASSERT_NEXT(a_final_stops, clk, rst_n, s1_adv && res_valid && res_status != ST_FOLLOW,
               finished_r)

endmodule
